### rtl/core/assert_macros.svh
// Assertion helpers for the RTL files; moab_back uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define MOAB_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define MOAB_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define MOAB_ASSERT(label, clk, rst, prop, msg)
`define MOAB_ASSERT_NEVER(label, clk, rst, cond, msg)
`endif
`endif

### rtl/core/moab_pkg.sv
package moab_pkg;

   localparam int DIVIDEND_WIDTH = 23;
   localparam int DIVISOR_WIDTH  = 13;
   localparam int CELLS_WIDTH    = 22;
   localparam int STEP_WIDTH     = 5;

   typedef enum logic [1:0] {
      OP_MASK_WRITE = 2'd0,
      OP_LUMA       = 2'd1,
      OP_CHROMA     = 2'd2,
      OP_NONE       = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_RANGE    = 2'd1,
      ST_OVERSIZE = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      REG_IMAGE_WIDTH   = 3'd0,
      REG_IMAGE_HEIGHT  = 3'd1,
      REG_MASK_WIDTH    = 3'd2,
      REG_MASK_HEIGHT   = 3'd3,
      REG_OVERLAY_LUMA  = 3'd4,
      REG_OVERLAY_BLUE  = 3'd5,
      REG_OVERLAY_RED   = 3'd6,
      REG_BLEND_WEIGHT  = 3'd7
   } reg_index_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_DIV,
      BK_MUL,
      BK_ADDR,
      BK_READ,
      BK_EMIT
   } back_state_type;

   typedef struct packed {
      opcode_type  opcode;
      logic [17:0] mask_index;
      logic [7:0]  mask_class;
      logic [11:0] pixel_row;
      logic [11:0] pixel_col;
      logic [7:0]  first_sample;
      logic [7:0]  second_sample;
   } item_type;

   typedef struct packed {
      logic [12:0] image_width;
      logic [12:0] image_height;
      logic [10:0] mask_width;
      logic [10:0] mask_height;
      logic [7:0]  overlay_luma;
      logic [7:0]  overlay_blue_diff;
      logic [7:0]  overlay_red_diff;
      logic [8:0]  blend_weight;
   } cfg_type;

   typedef struct packed {
      status_type  status;
      logic        was_marked;
      logic [7:0]  second_result;
      logic [7:0]  first_result;
   } result_type;

   // (old*(256-w) + colour*w) >> 8, w already saturated to 256
   function automatic logic [7:0] blend(logic [7:0] old, logic [7:0] colour, logic [8:0] w);
      logic [16:0] sum;
      sum = 17'(old) * 17'(9'd256 - w) + 17'(colour) * 17'(w);
      return sum[15:8];
   endfunction

endpackage

### rtl/core/moab_ram.sv
module moab_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    addr,
   input  logic [WIDTH-1:0] wdata,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

### rtl/core/moab_div.sv
module moab_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [moab_pkg::DIVIDEND_WIDTH-1:0] dividend,
   input  logic [moab_pkg::DIVISOR_WIDTH-1:0]  divisor,
   output logic                                busy,
   output logic [moab_pkg::DIVIDEND_WIDTH-1:0] quotient
);

   localparam int DW = moab_pkg::DIVIDEND_WIDTH;
   localparam int RW = moab_pkg::DIVISOR_WIDTH;

   logic                               busy_ff, busy_in;
   logic [moab_pkg::STEP_WIDTH-1:0]    step_ff, step_in;
   logic [DW-1:0]                      shift_ff, shift_in;
   logic [RW-1:0]                      rem_ff, rem_in;
   logic [RW-1:0]                      div_ff, div_in;
   logic [RW:0]                        trial;

   always_comb begin
      busy_in  = busy_ff;
      step_in  = step_ff;
      shift_in = shift_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      trial    = {rem_ff, shift_ff[DW-1]};
      if (start) begin
         busy_in  = 1'b1;
         step_in  = '0;
         shift_in = dividend;
         rem_in   = '0;
         div_in   = divisor;
      end else if (busy_ff) begin
         // one quotient bit per cycle, shifted in where the dividend bit left
         if (trial >= {1'b0, div_ff}) begin
            rem_in   = RW'(trial - {1'b0, div_ff});
            shift_in = {shift_ff[DW-2:0], 1'b1};
         end else begin
            rem_in   = trial[RW-1:0];
            shift_in = {shift_ff[DW-2:0], 1'b0};
         end
         step_in = step_ff + 1'b1;
         if (step_ff == moab_pkg::STEP_WIDTH'(DW - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
   end

   assign busy     = busy_ff;
   assign quotient = shift_ff;

endmodule

### rtl/core/moab_front.sv
module moab_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [71:0]        req_tdata,
   input  logic [1:0]         req_tuser,
   output logic               q_valid,
   output moab_pkg::item_type q_item,
   input  logic               q_pop
);

   moab_pkg::item_type fifo_ff [2];
   moab_pkg::item_type item;
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [1:0]         count_ff, count_in;
   logic               push;

   // classify: chroma pairs use the even top-left pixel
   always_comb begin
      item.opcode        = moab_pkg::opcode_type'(req_tuser);
      item.mask_index    = req_tdata[17:0];
      item.mask_class    = req_tdata[25:18];
      item.pixel_row     = req_tdata[37:26];
      item.pixel_col     = req_tdata[49:38];
      item.first_sample  = req_tdata[57:50];
      item.second_sample = req_tdata[65:58];
      if (item.opcode == moab_pkg::OP_CHROMA) begin
         item.pixel_row[0] = 1'b0;
         item.pixel_col[0] = 1'b0;
      end
   end

   assign req_tready = (count_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (count_ff != 2'd0);
   assign q_item     = fifo_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ q_pop;
      count_in  = count_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         fifo_ff[wr_ptr_ff] <= item;
      end
   end

endmodule

### rtl/core/moab_back.sv
`include "assert_macros.svh"

module moab_back #(
   parameter int MASK_DEPTH = 262144
) (
   input  logic                                clock,
   input  logic                                reset,
   input  moab_pkg::cfg_type                   cfg,
   input  logic [moab_pkg::CELLS_WIDTH-1:0]    cells,
   input  logic                                q_valid,
   input  moab_pkg::item_type                  q_item,
   output logic                                q_pop,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output moab_pkg::result_type                rsp_result
);

   localparam int AW = (MASK_DEPTH > 1) ? $clog2(MASK_DEPTH) : 1;
   localparam int DW = moab_pkg::DIVIDEND_WIDTH;
   localparam int CW = moab_pkg::CELLS_WIDTH;

   moab_pkg::back_state_type state_ff, state_in;
   moab_pkg::item_type       item_ff, item_in;
   moab_pkg::result_type     res_ff, res_in;
   moab_pkg::result_type     out_ff, out_in;
   logic                     out_valid_ff, out_valid_in;
   logic [10:0]              cr_ff, cr_in, cc_ff, cc_in;
   logic [CW-1:0]            prod_ff, prod_in;
   logic                     in_range_ff, in_range_in;
   logic                     oversized, out_free;
   logic                     div_start, row_busy, col_busy;
   logic [DW-1:0]            row_q, col_q, row_lim, col_lim;
   logic [12:0]              row_div, col_div;
   logic [CW-1:0]            ci;
   logic [31:0]              idx_wide, ci_wide;
   logic                     ram_we, ram_rdata;
   logic [AW-1:0]            ram_addr;
   logic [8:0]               weight;

   assign oversized = 32'(cells) > 32'(MASK_DEPTH);
   assign out_free  = !out_valid_ff || rsp_tready;
   assign row_div   = (cfg.image_height == '0) ? 13'd1 : cfg.image_height;
   assign col_div   = (cfg.image_width == '0) ? 13'd1 : cfg.image_width;
   assign row_lim   = DW'(cfg.mask_height) - 1'b1;
   assign col_lim   = DW'(cfg.mask_width) - 1'b1;
   assign weight    = (cfg.blend_weight > 9'd256) ? 9'd256 : cfg.blend_weight;
   assign ci        = prod_ff + CW'(cc_ff);
   assign idx_wide  = 32'(q_item.mask_index);
   assign ci_wide   = 32'(ci);

   moab_div u_row_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (DW'(q_item.pixel_row) * DW'(cfg.mask_height)),
      .divisor  (row_div),
      .busy     (row_busy),
      .quotient (row_q)
   );

   moab_div u_col_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (DW'(q_item.pixel_col) * DW'(cfg.mask_width)),
      .divisor  (col_div),
      .busy     (col_busy),
      .quotient (col_q)
   );

   moab_ram #(.WIDTH(1), .DEPTH(MASK_DEPTH)) u_mask_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (q_item.mask_class == 8'd1),
      .rdata (ram_rdata)
   );

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      res_in       = res_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      cr_in        = cr_ff;
      cc_in        = cc_ff;
      prod_in      = prod_ff;
      in_range_in  = in_range_ff;
      q_pop        = 1'b0;
      div_start    = 1'b0;
      ram_we       = 1'b0;
      ram_addr     = ci_wide[AW-1:0];
      case (state_ff)
         moab_pkg::BK_IDLE: begin
            ram_addr = idx_wide[AW-1:0];
            if (q_valid) begin
               q_pop   = 1'b1;
               item_in = q_item;
               res_in  = '0;
               state_in = moab_pkg::BK_EMIT;
               case (q_item.opcode)
                  moab_pkg::OP_MASK_WRITE: begin
                     if (oversized) begin
                        res_in.status = moab_pkg::ST_OVERSIZE;
                     end else if (CW'(q_item.mask_index) >= cells) begin
                        res_in.status = moab_pkg::ST_RANGE;
                     end else begin
                        ram_we = 1'b1;
                     end
                  end
                  moab_pkg::OP_LUMA, moab_pkg::OP_CHROMA: begin
                     res_in.first_result = q_item.first_sample;
                     if (q_item.opcode == moab_pkg::OP_CHROMA) begin
                        res_in.second_result = q_item.second_sample;
                     end
                     if (oversized) begin
                        res_in.status = moab_pkg::ST_OVERSIZE;
                     end else if (cells != '0) begin
                        div_start = 1'b1;
                        state_in  = moab_pkg::BK_DIV;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         moab_pkg::BK_DIV: begin
            if (!row_busy && !col_busy) begin
               // clamp to the last cell
               cr_in    = (row_q > row_lim) ? row_lim[10:0] : row_q[10:0];
               cc_in    = (col_q > col_lim) ? col_lim[10:0] : col_q[10:0];
               state_in = moab_pkg::BK_MUL;
            end
         end
         moab_pkg::BK_MUL: begin
            prod_in  = CW'(cr_ff) * CW'(cfg.mask_width);
            state_in = moab_pkg::BK_ADDR;
         end
         moab_pkg::BK_ADDR: begin
            in_range_in = ci < cells;
            state_in    = moab_pkg::BK_READ;
         end
         moab_pkg::BK_READ: begin
            if (in_range_ff && ram_rdata) begin
               res_in.was_marked = 1'b1;
               if (item_ff.opcode == moab_pkg::OP_LUMA) begin
                  res_in.first_result = moab_pkg::blend(item_ff.first_sample,
                                                        cfg.overlay_luma, weight);
               end else begin
                  res_in.first_result  = moab_pkg::blend(item_ff.first_sample,
                                                         cfg.overlay_blue_diff, weight);
                  res_in.second_result = moab_pkg::blend(item_ff.second_sample,
                                                         cfg.overlay_red_diff, weight);
               end
            end
            state_in = moab_pkg::BK_EMIT;
         end
         moab_pkg::BK_EMIT: begin
            if (out_free) begin
               out_in       = res_ff;
               out_valid_in = 1'b1;
               state_in     = moab_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = moab_pkg::BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= moab_pkg::BK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      item_ff     <= item_in;
      res_ff      <= res_in;
      out_ff      <= out_in;
      cr_ff       <= cr_in;
      cc_ff       <= cc_in;
      prod_ff     <= prod_in;
      in_range_ff <= in_range_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_result = out_ff;

   `MOAB_ASSERT_NEVER(a_we_idle, clock, reset, ram_we && state_ff != moab_pkg::BK_IDLE, "mask write outside idle")
   `MOAB_ASSERT(a_div_lockstep, clock, reset, (row_busy == col_busy), "dividers out of step")
   `MOAB_ASSERT(a_div_enter, clock, reset, div_start |=> (state_ff == moab_pkg::BK_DIV && row_busy), "divide not started")
   `MOAB_ASSERT(a_emit_done, clock, reset, (state_ff == moab_pkg::BK_EMIT && out_free) |=> (out_valid_ff && state_ff == moab_pkg::BK_IDLE), "result not issued")

endmodule

### rtl/core/mask_overlay_alpha_blend_top.sv
// A mask write, and a pixel item whose mask is oversized or empty, goes from idle straight to emit;
// other pixel items first pass the two bit-serial coordinate dividers running side by side,
// then the multiply, address and read states. One item is worked on at a time, and the emit
// state stalls until the output word is free. A 2-word queue decouples acceptance from execution.
// Reset (synchronous, active high) restores the register defaults and empties the
// queue and output; the mask store is not cleared.
module mask_overlay_alpha_blend_top #(
   parameter int MASK_DEPTH = 262144
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // mask_index, mask_class, pixel_row, pixel_col, first_sample, second_sample, zero pad
   input  logic [71:0] req_tdata,
   // opcode
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // first_result, second_result, was_marked, status, zero pad
   output logic [23:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [12:0] csr_wdata
);

   moab_pkg::cfg_type                cfg_ff, cfg_in;
   logic [moab_pkg::CELLS_WIDTH-1:0] cells_ff;
   logic                             q_valid, q_pop;
   moab_pkg::item_type               q_item;
   moab_pkg::result_type             result;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (moab_pkg::reg_index_type'(csr_index))
            moab_pkg::REG_IMAGE_WIDTH:  cfg_in.image_width       = csr_wdata;
            moab_pkg::REG_IMAGE_HEIGHT: cfg_in.image_height      = csr_wdata;
            moab_pkg::REG_MASK_WIDTH:   cfg_in.mask_width        = csr_wdata[10:0];
            moab_pkg::REG_MASK_HEIGHT:  cfg_in.mask_height       = csr_wdata[10:0];
            moab_pkg::REG_OVERLAY_LUMA: cfg_in.overlay_luma      = csr_wdata[7:0];
            moab_pkg::REG_OVERLAY_BLUE: cfg_in.overlay_blue_diff = csr_wdata[7:0];
            moab_pkg::REG_OVERLAY_RED:  cfg_in.overlay_red_diff  = csr_wdata[7:0];
            moab_pkg::REG_BLEND_WEIGHT: cfg_in.blend_weight      = csr_wdata[8:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width       <= 13'd1920;
         cfg_ff.image_height      <= 13'd1080;
         cfg_ff.mask_width        <= 11'd512;
         cfg_ff.mask_height       <= 11'd256;
         cfg_ff.overlay_luma      <= 8'd150;
         cfg_ff.overlay_blue_diff <= 8'd44;
         cfg_ff.overlay_red_diff  <= 8'd21;
         cfg_ff.blend_weight      <= 9'd102;
      end else begin
         cfg_ff <= cfg_in;
      end
      cells_ff <= moab_pkg::CELLS_WIDTH'(cfg_ff.mask_width) *
                  moab_pkg::CELLS_WIDTH'(cfg_ff.mask_height);
   end

   moab_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop)
   );

   moab_back #(.MASK_DEPTH(MASK_DEPTH)) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .cells      (cells_ff),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_result (result)
   );

   assign rsp_tdata = {5'b0, result};

endmodule

### sim/mask_overlay_alpha_blend_checker.sv
module mask_overlay_alpha_blend_checker #(
   parameter int MASK_DEPTH = 262144
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [71:0] req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [12:0] csr_wdata,
   output int          errors,
   output int          pending
);

   moab_pkg::cfg_type    regs;
   bit                   drivable [MASK_DEPTH];
   moab_pkg::result_type blend_queue [$];

   initial begin
      errors  = 0;
      pending = 0;
   end

   function automatic longint store_cells();
      return longint'(regs.mask_width) * longint'(regs.mask_height);
   endfunction

   function automatic bit store_full();
      return store_cells() > MASK_DEPTH;
   endfunction

   function automatic longint nearest(longint coord, longint cells, longint size);
      longint d, q;
      d = (size == 0) ? 1 : size;
      q = coord * cells / d;
      return (q > cells - 1) ? cells - 1 : q;
   endfunction

   // mask cell read by a pixel word, or -1 when no read happens
   function automatic longint cell_of(moab_pkg::opcode_type op, logic [11:0] row,
                                      logic [11:0] col);
      logic [11:0] r, c;
      r = row;
      c = col;
      if (op == moab_pkg::OP_CHROMA) begin
         r[0] = 1'b0;
         c[0] = 1'b0;
      end
      if (store_full() || store_cells() == 0) return -1;
      return nearest(r, regs.mask_height, regs.image_height) * regs.mask_width
             + nearest(c, regs.mask_width, regs.image_width);
   endfunction

   function automatic logic [7:0] mix(logic [7:0] old, logic [7:0] colour, int w);
      int s;
      s = int'(old) * (256 - w) + int'(colour) * w;
      return 8'(s >> 8);
   endfunction

   function automatic moab_pkg::result_type predict(moab_pkg::opcode_type op, logic [71:0] d);
      moab_pkg::result_type res;
      logic [17:0]          idx;
      longint               ci;
      int                   w;
      idx = d[17:0];
      res = '0;
      res.status = moab_pkg::ST_OK;
      w = (regs.blend_weight > 256) ? 256 : int'(regs.blend_weight);
      if (op == moab_pkg::OP_MASK_WRITE) begin
         if (store_full()) res.status = moab_pkg::ST_OVERSIZE;
         else if (idx >= store_cells()) res.status = moab_pkg::ST_RANGE;
         else drivable[idx] = (d[25:18] == 8'd1);
      end else if (op == moab_pkg::OP_LUMA || op == moab_pkg::OP_CHROMA) begin
         res.first_result  = d[57:50];
         res.second_result = (op == moab_pkg::OP_CHROMA) ? d[65:58] : 8'd0;
         if (store_full()) res.status = moab_pkg::ST_OVERSIZE;
         else begin
            ci = cell_of(op, d[37:26], d[49:38]);
            if (ci >= 0 && drivable[ci]) begin
               res.was_marked = 1'b1;
               if (op == moab_pkg::OP_LUMA) begin
                  res.first_result = mix(d[57:50], regs.overlay_luma, w);
               end else begin
                  res.first_result  = mix(d[57:50], regs.overlay_blue_diff, w);
                  res.second_result = mix(d[65:58], regs.overlay_red_diff, w);
               end
            end
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin
      moab_pkg::result_type want, got;
      if (reset) begin
         regs <= '{13'd1920, 13'd1080, 11'd512, 11'd256, 8'd150, 8'd44, 8'd21, 9'd102};
         blend_queue.delete();
      end else begin
         if (csr_we) begin
            case (moab_pkg::reg_index_type'(csr_index))
               moab_pkg::REG_IMAGE_WIDTH:  regs.image_width       <= csr_wdata;
               moab_pkg::REG_IMAGE_HEIGHT: regs.image_height      <= csr_wdata;
               moab_pkg::REG_MASK_WIDTH:   regs.mask_width        <= csr_wdata[10:0];
               moab_pkg::REG_MASK_HEIGHT:  regs.mask_height       <= csr_wdata[10:0];
               moab_pkg::REG_OVERLAY_LUMA: regs.overlay_luma      <= csr_wdata[7:0];
               moab_pkg::REG_OVERLAY_BLUE: regs.overlay_blue_diff <= csr_wdata[7:0];
               moab_pkg::REG_OVERLAY_RED:  regs.overlay_red_diff  <= csr_wdata[7:0];
               moab_pkg::REG_BLEND_WEIGHT: regs.blend_weight      <= csr_wdata[8:0];
               default: begin
               end
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got.first_result  = rsp_tdata[7:0];
            got.second_result = rsp_tdata[15:8];
            got.was_marked    = rsp_tdata[16];
            got.status        = moab_pkg::status_type'(rsp_tdata[18:17]);
            if (blend_queue.size() == 0) begin
               $display("%0t: unexpected result word %h", $time, rsp_tdata);
               errors <= errors + 1;
            end else begin
               want = blend_queue.pop_front();
               if (got != want) begin
                  $display("%0t: first exp %0d act %0d, second exp %0d act %0d", $time,
                           want.first_result, got.first_result,
                           want.second_result, got.second_result);
                  $display("%0t: marked exp %0d act %0d, status exp %0d act %0d", $time,
                           want.was_marked, got.was_marked, want.status, got.status);
                  errors <= errors + 1;
               end
            end
         end
         if (req_tvalid && req_tready)
            blend_queue.push_back(predict(moab_pkg::opcode_type'(req_tuser), req_tdata));
      end
      pending <= blend_queue.size();
   end

endmodule

### sim/mask_overlay_alpha_blend_top_tb.sv
module mask_overlay_alpha_blend_top_tb;

   localparam int DEPTH = 262144;
   localparam int LIMIT = 600000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [12:0] csr_wdata = '0;
   int          errors, pending;

   bit written [DEPTH];
   bit quiet = 1'b0;
   bit long_hold = 1'b0;
   int sent_words = 0;
   int write_words = 0;
   int settings = 0;

   mask_overlay_alpha_blend_top #(.MASK_DEPTH(DEPTH)) dut (.*);

   mask_overlay_alpha_blend_checker #(.MASK_DEPTH(DEPTH)) chk (.*);

   initial forever #2 clock = ~clock;

   initial begin
      repeat (LIMIT) @(posedge clock);
      $display("timeout after %0d cycles", LIMIT);
      $display("** mask_overlay_alpha_blend_top: FAILED **");
      $finish;
   end

   // receiver: random stalls, quiet stretches, one long hold-off
   initial begin
      int n;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (long_hold) begin
            long_hold = 1'b0;
            rsp_tready <= 1'b0;
            repeat (300) @(posedge clock);
         end
         n = quiet ? 0 : $urandom_range(0, 4);
         if (n > 0) begin
            rsp_tready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   function automatic logic [7:0] pick_class();
      return ($urandom_range(0, 1) != 0) ? 8'd1 : 8'($urandom);
   endfunction

   task automatic send(moab_pkg::opcode_type op, logic [17:0] idx, logic [7:0] cls,
                       logic [11:0] row, logic [11:0] col, logic [7:0] s0, logic [7:0] s1);
      int n;
      n = quiet ? 0 : $urandom_range(0, 4);
      if (n > 0) begin
         req_tvalid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {6'd0, s1, s0, col, row, cls, idx};
      do @(posedge clock); while (!req_tready);
      sent_words++;
   endtask

   task automatic put_write(logic [17:0] idx, logic [7:0] cls);
      send(moab_pkg::OP_MASK_WRITE, idx, cls, 12'($urandom), 12'($urandom), 8'($urandom),
           8'($urandom));
      write_words++;
      if (!chk.store_full() && idx < chk.store_cells()) written[idx] = 1'b1;
   endtask

   // write the mapped cell first if it was never written
   task automatic put_pixel(moab_pkg::opcode_type op, logic [11:0] row, logic [11:0] col,
                            logic [7:0] s0, logic [7:0] s1);
      longint ci;
      ci = chk.cell_of(op, row, col);
      if (ci >= 0 && !written[ci]) put_write(18'(ci), pick_class());
      send(op, 18'($urandom), 8'($urandom), row, col, s0, s1);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic set_regs(int iw, int ih, int mw, int mh, int y, int u, int v, int w);
      int vals [8];
      vals = '{iw, ih, mw, mh, y, u, v, w};
      for (int i = 0; i < 8; i++) begin
         csr_we    <= 1'b1;
         csr_index <= moab_pkg::reg_index_type'(i);
         csr_wdata <= 13'(vals[i]);
         @(posedge clock);
      end
      csr_we <= 1'b0;
      @(posedge clock);
      settings++;
   endtask

   task automatic random_words(int count);
      int     pick;
      longint cells;
      for (int k = 0; k < count; k++) begin
         quiet = ((k / 80) % 3) == 2;
         cells = chk.store_cells();
         pick = $urandom_range(0, 99);
         if (pick < 25 && !chk.store_full() && cells > 0)
            put_write(18'($urandom_range(0, int'(cells) - 1)), pick_class());
         else if (pick < 32)
            put_write(18'($urandom), 8'($urandom));
         else if (pick < 35)
            send(moab_pkg::OP_NONE, 18'($urandom), 8'($urandom), 12'($urandom),
                 12'($urandom), 8'($urandom), 8'($urandom));
         else
            put_pixel(($urandom_range(0, 1) != 0) ? moab_pkg::OP_LUMA : moab_pkg::OP_CHROMA,
                      12'($urandom), 12'($urandom), 8'($urandom), 8'($urandom));
      end
      quiet = 1'b0;
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, reset register values
      put_write(18'd0, 8'd1);
      put_write(18'd131071, 8'd1);
      put_write(18'd262143, 8'd1);
      put_write(18'd6, 8'd0);
      put_write(18'd5, 8'd255);
      send(moab_pkg::OP_NONE, '1, '1, '1, '1, '1, '1);
      put_pixel(moab_pkg::OP_LUMA, 12'd0, 12'd0, 8'd0, 8'd255);
      put_pixel(moab_pkg::OP_LUMA, 12'd0, 12'd0, 8'd255, 8'd0);
      put_pixel(moab_pkg::OP_LUMA, 12'd0, 12'd23, 8'd77, 8'd0);
      put_pixel(moab_pkg::OP_CHROMA, 12'd1, 12'd1, 8'd255, 8'd0);
      put_pixel(moab_pkg::OP_CHROMA, 12'd4095, 12'd4095, 8'd0, 8'd255);
      put_pixel(moab_pkg::OP_CHROMA, 12'd1079, 12'd1919, 8'd128, 8'd128);
      long_hold = 1'b1;
      random_words(200);
      drain();

      // small mask, full weight, colour extremes
      set_regs(64, 48, 8, 6, 255, 0, 255, 256);
      random_words(200);
      drain();
      // zero weight, zero image width, one-cell mask
      set_regs(0, 1, 1, 1, 0, 255, 0, 0);
      random_words(150);
      drain();
      // weight saturation, mask exactly fills the store
      set_regs(4096, 4096, 512, 512, 170, 85, 200, 511);
      random_words(200);
      drain();
      // oversized mask, all register bits high except the blend weight
      set_regs(8191, 8191, 2047, 2047, 255, 255, 255, 257);
      random_words(150);
      drain();
      set_regs(1920, 1080, 1024, 1024, 16, 128, 128, 102);
      random_words(100);
      drain();
      // zero mask dimension
      set_regs(640, 480, 0, 20, 1, 2, 3, 128);
      random_words(150);
      drain();
      // coordinates far outside a narrow image
      set_regs(100, 3000, 1024, 256, 90, 240, 35, 1);
      random_words(200);
      drain();

      $display("sent %0d words (%0d mask writes) across %0d register settings", sent_words,
               write_words, settings + 1);
      $display("covered oversized, zero-size, saturated-weight and clamped mappings");
      if (errors == 0)
         $display("** mask_overlay_alpha_blend_top: PASSED **");
      else
         $display("** mask_overlay_alpha_blend_top: FAILED **");
      $finish;
   end

endmodule

### files.f
+incdir+rtl/core
rtl/core/moab_pkg.sv
rtl/core/moab_ram.sv
rtl/core/moab_div.sv
rtl/core/moab_front.sv
rtl/core/moab_back.sv
rtl/core/mask_overlay_alpha_blend_top.sv
sim/mask_overlay_alpha_blend_checker.sv
sim/mask_overlay_alpha_blend_top_tb.sv
